// ===== rtl/hgcd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and step functions for the haversine distance core.
package hgcd_pkg;

   // Fixed-point format and pipeline lengths.
   localparam int CORDIC_STEPS = 32;
   localparam int FRAC         = 60;
   localparam int SIN_TERMS    = 14;
   localparam int MULQ_LAT     = 2;
   localparam int SQRT_STEPS   = FRAC + 1;
   localparam int HAV_LAT      = MULQ_LAT + SIN_TERMS * (MULQ_LAT + 1) + MULQ_LAT;
   localparam int PIPE_LAT     = 4 + HAV_LAT + 1 + MULQ_LAT + 1 + SQRT_STEPS
                                 + CORDIC_STEPS + 1 + FRAC + 3;

   // Field widths.
   localparam int RADIUS_W = 33;
   localparam int DIST_W   = 35;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 33'd6372797561;

   // Angle constants: one and pi in Q3.60, turns in units of 1e-7 degree.
   localparam logic [63:0]        ONE_Q   = 64'd1 << FRAC;
   localparam logic signed [63:0] ONE_S   = 64'sd1 <<< FRAC;
   localparam logic [63:0]        PI_Q    = 64'h3243F6A8885A308D;
   localparam logic [63:0]        FULL_TURN = 64'd3600000000;
   localparam logic signed [33:0] FULL_S  = 34'sd3600000000;
   localparam logic signed [33:0] HALF_S  = 34'sd1800000000;

   // Factor from units of 1e-7 degree to Q3.60 radians of the half angle, scaled by 2^32.
   localparam logic [63:0] CONV_Q1 = PI_Q / FULL_TURN;
   localparam logic [63:0] CONV_R1 = PI_Q % FULL_TURN;
   localparam logic [63:0] CONV    = (CONV_Q1 << 32) | ((CONV_R1 << 32) / FULL_TURN);
   localparam logic [31:0] CONV_HI = CONV[63:32];
   localparam logic [31:0] CONV_LO = CONV[31:0];

   // State of one bit-serial square root step.
   typedef struct packed {
      logic [121:0] rem;
      logic [60:0]  root;
   } sqrt_state_type;

   // State of one CORDIC vectoring step.
   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } cordic_state_type;

   // State of one restoring division step, with the angle riding along.
   typedef struct packed {
      logic [63:0]        rem;
      logic [59:0]        quo;
      logic [63:0]        den;
      logic signed [63:0] z;
      logic               apply;
      logic               neg;
   } div_state_type;

   // Arctangent of 2^-i in Q3.60, from its alternating series.
   function automatic logic [63:0] atan_q(input int i);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] term;
      if (i == 0) begin
         return PI_Q >> 2;
      end
      p   = 64'd1 << (FRAC - i);
      sum = '0;
      for (int k = 0; k < 64; k++) begin
         if (p != 64'd0) begin
            term = p / 64'(2 * k + 1);
            sum  = (k % 2 == 1) ? sum - term : sum + term;
            p    = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
         end
      end
      return sum;
   endfunction

   // Wrap an angle difference into one turn and return its magnitude.
   function automatic logic [30:0] reduce_mag(input logic signed [32:0] d);
      logic signed [33:0] w;
      logic signed [33:0] r;
      logic signed [33:0] n;
      w = {d[32], d};
      if (w >= HALF_S) begin
         r = w - FULL_S;
      end else if (w < -HALF_S) begin
         r = w + FULL_S;
      end else begin
         r = w;
      end
      n = -r;
      return r[33] ? n[30:0] : r[30:0];
   endfunction

   // One result bit of floor(sqrt(N)).
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s, input int b);
      sqrt_state_type o;
      logic [121:0] trial;
      trial = ({61'd0, s.root} << (b + 1)) + (122'd1 << (2 * b));
      o = s;
      if (s.rem >= trial) begin
         o.rem  = s.rem - trial;
         o.root = s.root | (61'd1 << b);
      end
      return o;
   endfunction

   // One CORDIC rotation toward y = 0.
   function automatic cordic_state_type cordic_step(input cordic_state_type s, input int i,
                                                    input logic signed [63:0] at);
      cordic_state_type o;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      dx = s.y >>> i;
      dy = s.x >>> i;
      if (!s.y[63]) begin
         o.x = s.x + dx;
         o.y = s.y - dy;
         o.z = s.z + at;
      end else begin
         o.x = s.x - dx;
         o.y = s.y + dy;
         o.z = s.z - at;
      end
      return o;
   endfunction

   // One quotient bit of the residual correction.
   function automatic div_state_type div_step(input div_state_type s);
      div_state_type o;
      logic [63:0] r2;
      logic        ge;
      o  = s;
      r2 = {s.rem[62:0], 1'b0};
      ge = (r2 >= s.den);
      o.rem = ge ? (r2 - s.den) : r2;
      o.quo = {s.quo[58:0], ge};
      return o;
   endfunction

endpackage

// ===== rtl/hgcd_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the haversine distance core.

// Point pair channel.
interface hgcd_req_if;
   logic               valid;
   logic               ready;
   logic signed [30:0] lat_first;
   logic signed [31:0] lon_first;
   logic signed [30:0] lat_second;
   logic signed [31:0] lon_second;
   modport source (output valid, lat_first, lon_first, lat_second, lon_second, input ready);
   modport sink (input valid, lat_first, lon_first, lat_second, lon_second, output ready);
endinterface

// Distance result channel.
interface hgcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [34:0] distance_mm;
   modport source (output valid, distance_mm, input ready);
   modport sink (input valid, distance_mm, output ready);
endinterface

// Radius register write channel.
interface hgcd_csr_if;
   logic        valid;
   logic        ready;
   logic [32:0] sphere_radius_mm;
   modport source (output valid, sphere_radius_mm, input ready);
   modport sink (input valid, sphere_radius_mm, output ready);
endinterface

// ===== rtl/hgcd_mulq.sv =====
`timescale 1ns / 1ps
// Two-stage 64 by 64 multiplier that returns the product shifted right by the fraction width.
module hgcd_mulq (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0]  ll_ff;
   logic [63:0]  lh_ff;
   logic [63:0]  hl_ff;
   logic [63:0]  hh_ff;
   logic [127:0] full;
   logic [63:0]  p_ff;

   // First stage: four 32 by 32 partial products.
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= a[31:0] * b[31:0];
         lh_ff <= a[31:0] * b[63:32];
         hl_ff <= a[63:32] * b[31:0];
         hh_ff <= a[63:32] * b[63:32];
      end
   end

   // Second stage: sum and take the Q3.60 slice.
   assign full = {hh_ff, 64'd0} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0}
                 + {64'd0, ll_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= full[hgcd_pkg::FRAC+63:hgcd_pkg::FRAC];
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/hgcd_hav.sv =====
`timescale 1ns / 1ps
// Pipelined haversine of a half angle: Taylor sine, clamp, then square.
module hgcd_hav (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] theta,
   output logic [63:0] hav
);

   localparam int LAT = hgcd_pkg::MULQ_LAT;
   localparam int NT  = hgcd_pkg::SIN_TERMS;

   logic [63:0]        sq;
   logic [63:0]        th_d_ff [LAT];
   logic [63:0]        t_st  [NT+1];
   logic signed [63:0] s_st  [NT+1];
   logic [63:0]        sq_st [NT+1];
   logic signed [63:0] s_end;
   logic [63:0]        s_clamp;

   // Square of the angle, with the angle delayed to match.
   hgcd_mulq u_sq (.clock(clock), .en(en), .a(theta), .b(theta), .p(sq));

   always_ff @(posedge clock) begin
      if (en) begin
         th_d_ff[0] <= theta;
         for (int i = 1; i < LAT; i++) begin
            th_d_ff[i] <= th_d_ff[i-1];
         end
      end
   end

   assign t_st[0]  = th_d_ff[LAT-1];
   assign s_st[0]  = th_d_ff[LAT-1];
   assign sq_st[0] = sq;

   // One series term per group of stages.
   for (genvar j = 0; j < NT; j++) begin : g_term
      localparam logic [63:0] DIV = 64'((2 * (j + 1)) * (2 * (j + 1) + 1));
      logic [63:0]        p;
      logic [63:0]        t_next;
      logic signed [63:0] s_d_ff  [LAT];
      logic [63:0]        sq_d_ff [LAT];
      logic [63:0]        t_ff;
      logic signed [63:0] s_ff;
      logic [63:0]        sq_ff;

      hgcd_mulq u_term (.clock(clock), .en(en), .a(t_st[j]), .b(sq_st[j]), .p(p));

      always_ff @(posedge clock) begin
         if (en) begin
            s_d_ff[0]  <= s_st[j];
            sq_d_ff[0] <= sq_st[j];
            for (int i = 1; i < LAT; i++) begin
               s_d_ff[i]  <= s_d_ff[i-1];
               sq_d_ff[i] <= sq_d_ff[i-1];
            end
         end
      end

      assign t_next = p / DIV;

      // Odd terms subtract, even terms add.
      always_ff @(posedge clock) begin
         if (en) begin
            t_ff  <= t_next;
            s_ff  <= (j % 2 == 0) ? s_d_ff[LAT-1] - signed'(t_next)
                                  : s_d_ff[LAT-1] + signed'(t_next);
            sq_ff <= sq_d_ff[LAT-1];
         end
      end

      assign t_st[j+1]  = t_ff;
      assign s_st[j+1]  = s_ff;
      assign sq_st[j+1] = sq_ff;
   end

   // Clamp the sine to [0, 1] and square it.
   assign s_end = s_st[NT];

   always_comb begin
      if (s_end[63]) begin
         s_clamp = '0;
      end else if (s_end > hgcd_pkg::ONE_S) begin
         s_clamp = hgcd_pkg::ONE_Q;
      end else begin
         s_clamp = s_end;
      end
   end

   hgcd_mulq u_sin2 (.clock(clock), .en(en), .a(s_clamp), .b(s_clamp), .p(hav));

endmodule

// ===== rtl/haversine_great_circle_distance_core.sv =====
`timescale 1ns / 1ps
// Top level of the haversine great-circle distance core.
// The core takes one point pair per clock while not stalled and returns one distance per
// pair, in order.
// The pipeline depth is set by the chain of single-bit stages: 61 square root stages, 32 CORDIC
// stages and 60 divide stages, after the 46-stage Taylor haversine. Every stage holds
// while the result register waits to be taken, so nothing is lost under back pressure.
// The radius register may be written at any time but must only change while no item is
// in flight.
module haversine_great_circle_distance_core (
   input logic       clock,
   input logic       reset,
   hgcd_req_if.sink  req_ch,
   hgcd_rsp_if.source rsp_ch,
   hgcd_csr_if.sink  csr_ch
);

   localparam int LAT = hgcd_pkg::MULQ_LAT;
   localparam int NSQ = hgcd_pkg::SQRT_STEPS;
   localparam int NC  = hgcd_pkg::CORDIC_STEPS;
   localparam int ND  = hgcd_pkg::FRAC;
   localparam int PL  = hgcd_pkg::PIPE_LAT;

   logic                            en;
   logic [PL-1:0]                   vld_ff;
   logic [PL-1:0]                   vld_in;
   logic [hgcd_pkg::RADIUS_W-1:0]   radius_ff;

   logic signed [32:0] s0_d_ff  [3];
   logic [30:0]        s1_m_ff  [3];
   logic [62:0]        s2_hi_ff [3];
   logic [62:0]        s2_lo_ff [3];
   logic [63:0]        s3_th_ff [3];
   logic [63:0]        hv       [3];

   logic signed [63:0] cp;
   logic [63:0]        cp_abs_ff;
   logic               cp_neg_ff;
   logic [63:0]        hd_ff;
   logic [63:0]        hl_ff;
   logic [63:0]        prod;
   logic [63:0]        hd_d_ff  [LAT];
   logic               neg_d_ff [LAT];
   logic signed [63:0] a_s;
   logic [60:0]        a_ff;

   hgcd_pkg::sqrt_state_type   sa_st [NSQ+1];
   hgcd_pkg::sqrt_state_type   ca_st [NSQ+1];
   hgcd_pkg::cordic_state_type cr_st [NC+1];
   hgcd_pkg::div_state_type    dv_st [ND+1];
   hgcd_pkg::div_state_type    d0_in;

   logic [63:0]        ay;
   logic signed [63:0] zf;
   logic signed [63:0] corr;
   logic [62:0]        z_ff;
   logic [64:0]        m_lo_ff;
   logic [63:0]        m_hi_ff;
   logic [96:0]        sum;
   logic [hgcd_pkg::DIST_W-1:0] dist_ff;

   // The whole pipeline advances unless the result register is stalled.
   assign en           = !vld_ff[PL-1] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign vld_in       = {vld_ff[PL-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Radius register.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= hgcd_pkg::RADIUS_RESET;
      end else if (csr_ch.valid) begin
         radius_ff <= csr_ch.sphere_radius_mm;
      end
   end

   // Angle differences and sums in 1e-7 degree.
   always_ff @(posedge clock) begin
      if (en) begin
         s0_d_ff[0] <= {{2{req_ch.lat_second[30]}}, req_ch.lat_second}
                       - {{2{req_ch.lat_first[30]}}, req_ch.lat_first};
         s0_d_ff[1] <= {{2{req_ch.lat_first[30]}}, req_ch.lat_first}
                       + {{2{req_ch.lat_second[30]}}, req_ch.lat_second};
         s0_d_ff[2] <= {req_ch.lon_second[31], req_ch.lon_second}
                       - {req_ch.lon_first[31], req_ch.lon_first};
      end
   end

   // Wrap, take magnitude, convert to Q3.60 radians of the half angle.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s1_m_ff[k]  <= hgcd_pkg::reduce_mag(s0_d_ff[k]);
            s2_hi_ff[k] <= s1_m_ff[k] * hgcd_pkg::CONV_HI;
            s2_lo_ff[k] <= s1_m_ff[k] * hgcd_pkg::CONV_LO;
            s3_th_ff[k] <= {1'b0, s2_hi_ff[k]} + {33'd0, s2_lo_ff[k][62:32]};
         end
      end
   end

   // Three haversine pipelines.
   for (genvar k = 0; k < 3; k++) begin : g_hav
      hgcd_hav u_hav (.clock(clock), .en(en), .theta(s3_th_ff[k]), .hav(hv[k]));
   end

   // Cosine product term.
   assign cp = hgcd_pkg::ONE_S - signed'(hv[0]) - signed'(hv[1]);

   always_ff @(posedge clock) begin
      if (en) begin
         cp_neg_ff <= cp[63];
         cp_abs_ff <= cp[63] ? 64'(-cp) : cp;
         hd_ff     <= hv[0];
         hl_ff     <= hv[2];
         hd_d_ff[0]  <= hd_ff;
         neg_d_ff[0] <= cp_neg_ff;
         for (int i = 1; i < LAT; i++) begin
            hd_d_ff[i]  <= hd_d_ff[i-1];
            neg_d_ff[i] <= neg_d_ff[i-1];
         end
      end
   end

   hgcd_mulq u_prod (.clock(clock), .en(en), .a(cp_abs_ff), .b(hl_ff), .p(prod));

   // Haversine of the central angle, clamped to [0, 1].
   assign a_s = neg_d_ff[LAT-1] ? signed'(hd_d_ff[LAT-1]) - signed'(prod)
                                : signed'(hd_d_ff[LAT-1]) + signed'(prod);

   always_ff @(posedge clock) begin
      if (en) begin
         if (a_s[63]) begin
            a_ff <= '0;
         end else if (a_s > hgcd_pkg::ONE_S) begin
            a_ff <= hgcd_pkg::ONE_Q[60:0];
         end else begin
            a_ff <= a_s[60:0];
         end
      end
   end

   // Square roots of a and 1 - a, one result bit per stage.
   assign sa_st[0].rem  = {1'b0, a_ff, 60'd0};
   assign sa_st[0].root = '0;
   assign ca_st[0].rem  = {1'b0, hgcd_pkg::ONE_Q[60:0] - a_ff, 60'd0};
   assign ca_st[0].root = '0;

   for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sa_st[g+1] <= hgcd_pkg::sqrt_step(sa_st[g], NSQ - 1 - g);
            ca_st[g+1] <= hgcd_pkg::sqrt_step(ca_st[g], NSQ - 1 - g);
         end
      end
   end

   // CORDIC vectoring for atan2(sqrt(a), sqrt(1 - a)).
   assign cr_st[0].x = {3'd0, ca_st[NSQ].root};
   assign cr_st[0].y = {3'd0, sa_st[NSQ].root};
   assign cr_st[0].z = '0;

   for (genvar i = 0; i < NC; i++) begin : g_cordic
      localparam logic signed [63:0] AT = hgcd_pkg::atan_q(i);
      always_ff @(posedge clock) begin
         if (en) begin
            cr_st[i+1] <= hgcd_pkg::cordic_step(cr_st[i], i, AT);
         end
      end
   end

   // Set up the residual correction y / x.
   assign ay = cr_st[NC].y[63] ? 64'(-cr_st[NC].y) : cr_st[NC].y;

   always_comb begin
      d0_in.rem   = ay;
      d0_in.quo   = '0;
      d0_in.den   = cr_st[NC].x;
      d0_in.z     = cr_st[NC].z;
      d0_in.neg   = cr_st[NC].y[63];
      d0_in.apply = !cr_st[NC].x[63] && (cr_st[NC].x != 64'd0) && (ay != 64'd0)
                    && (ay < cr_st[NC].x);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_st[0] <= d0_in;
      end
   end

   for (genvar i = 0; i < ND; i++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            dv_st[i+1] <= hgcd_pkg::div_step(dv_st[i]);
         end
      end
   end

   // Apply the correction and clamp the angle at zero.
   assign corr = {4'd0, dv_st[ND].quo};
   assign zf   = !dv_st[ND].apply ? dv_st[ND].z
               : (dv_st[ND].neg ? dv_st[ND].z - corr : dv_st[ND].z + corr);

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff <= zf[63] ? 63'd0 : zf[62:0];
      end
   end

   // Scale by twice the radius and round to the nearest millimetre.
   always_ff @(posedge clock) begin
      if (en) begin
         m_lo_ff <= z_ff[31:0] * radius_ff;
         m_hi_ff <= z_ff[62:32] * radius_ff;
      end
   end

   assign sum = {1'b0, m_hi_ff, 32'd0} + {32'd0, m_lo_ff} + (97'd1 << 58);

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= sum[93:59];
      end
   end

   assign rsp_ch.valid       = vld_ff[PL-1];
   assign rsp_ch.distance_mm = dist_ff;

endmodule
